FILE: design/whpp_pkg.sv
// Package for the windowed histogram peak picker: field widths, default sizes,
// controller state type and the command and status groups between controller
// and datapath. Depends on nothing.
`default_nettype none

package whpp_pkg;

  // Default sizes of the bin store and of the window list.
  localparam int MAX_BINS_DEF    = 1024;
  localparam int MAX_WINDOWS_DEF = 16;

  // Fixed payload widths.
  localparam int BIN_COUNT_W   = 24;
  localparam int PEAK_BIN_W    = 11;
  localparam int NUM_WINDOWS_W = 5;

  // Reset value of the window count register.
  localparam logic [NUM_WINDOWS_W-1:0] NUM_WINDOWS_RST = 5'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_WIN,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // take bins from the input channel
    logic div_step;    // one step of the width divider
    logic pass_init;   // restart the window walk for a pass
    logic pass_sel;    // 1 selects the half-width shifted pass
    logic win_setup;   // work out the bounds of the current window
    logic scan_step;   // read the next bin of the current window
    logic fp_store;    // keep the window maximum as a first-pass peak
    logic next_win;    // advance to the next window
    logic out_load;    // put a result into the output register
    logic out_sel_fp;  // result comes from the first-pass store
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_last;   // last bin of the histogram transferred this cycle
    logic div_done;   // window width is ready
    logic win_empty;  // current window holds no bins
    logic scan_last;  // the last bin of the window is being read
    logic last_win;   // current window is the final one
    logic close_any;  // two neighbouring first-pass peaks are too close
    logic pass;       // shifted pass in progress
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

FILE: design/whpp_channels.sv
// Channel interfaces of the windowed histogram peak picker: bin input, peak
// output and the window count write channel. Depends on whpp_pkg.
`default_nettype none

interface whpp_in_if;
  logic                             valid;
  logic                             ready;
  logic [whpp_pkg::BIN_COUNT_W-1:0] bin_count;
  logic                             last_bin;

  modport source (output valid, output bin_count, output last_bin, input ready);
  modport sink   (input valid, input bin_count, input last_bin, output ready);
endinterface

interface whpp_out_if;
  logic                             valid;
  logic                             ready;
  logic [whpp_pkg::PEAK_BIN_W-1:0]  peak_bin;
  logic [whpp_pkg::BIN_COUNT_W-1:0] peak_count;
  logic                             window_shifted;
  logic                             last_peak;

  modport source (output valid, output peak_bin, output peak_count,
                  output window_shifted, output last_peak, input ready);
  modport sink   (input valid, input peak_bin, input peak_count,
                  input window_shifted, input last_peak, output ready);
endinterface

interface whpp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [whpp_pkg::NUM_WINDOWS_W-1:0] num_windows;

  modport source (output valid, output num_windows, input ready);
  modport sink   (input valid, input num_windows, output ready);
endinterface

`default_nettype wire

FILE: design/windowed_histogram_peak_picker.sv
// Top level of the windowed histogram peak picker: joins the controller and
// the datapath. Depends on whpp_pkg, the channel interfaces, whpp_ctrl and
// whpp_datapath.
//
//   Channel  Direction  Payload                                           Transfer
//   in_ch    sink       bin_count[23:0], last_bin                         valid & ready
//   out_ch   source     peak_bin[10:0], peak_count[23:0],
//                       window_shifted, last_peak                         valid & ready
//   cfg_ch   sink       num_windows[4:0]                                  valid & ready
//
// Bins are taken one per cycle while the block is loading.
// After the last bin the width divider runs; then each window is set up, read
// one bin per cycle from the store's single read port and closed, or set up
// and closed at once when the window is empty of bins.
// A shifted pass repeats the scan; otherwise results leave one per cycle
// while out_ch takes them. The output register holds one result; a stall on
// out_ch stops the walk only when a new result must be loaded. Reset is
// synchronous; the bin store needs no clearing pass.
`default_nettype none

module windowed_histogram_peak_picker #(
  parameter int MAX_BINS    = whpp_pkg::MAX_BINS_DEF,
  parameter int MAX_WINDOWS = whpp_pkg::MAX_WINDOWS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  whpp_in_if.sink     in_ch,
  whpp_out_if.source  out_ch,
  whpp_cfg_if.sink    cfg_ch
);

  whpp_pkg::cmd_t cmd;
  whpp_pkg::sts_t sts;

  // Sequencer.
  whpp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Store, divider, scan and output.
  whpp_datapath #(
    .MAX_BINS    (MAX_BINS),
    .MAX_WINDOWS (MAX_WINDOWS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

FILE: design/whpp_ctrl.sv
// Controller of the windowed histogram peak picker: sequences loading, the
// width division, both scan passes and result output. Depends on whpp_pkg.
`default_nettype none

module whpp_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  whpp_pkg::sts_t   sts,
  output whpp_pkg::cmd_t   cmd
);

  whpp_pkg::state_t state_r;
  whpp_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= whpp_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      whpp_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        if (sts.acc_last) begin
          state_nxt = whpp_pkg::ST_DIV;
        end
      end
      whpp_pkg::ST_DIV: begin
        if (!sts.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.pass_init = 1'b1;
          cmd.pass_sel  = 1'b0;
          state_nxt     = whpp_pkg::ST_WIN;
        end
      end
      whpp_pkg::ST_WIN: begin
        cmd.win_setup = 1'b1;
        state_nxt     = sts.win_empty ? whpp_pkg::ST_RESULT : whpp_pkg::ST_SCAN;
      end
      whpp_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = whpp_pkg::ST_DRAIN;
        end
      end
      whpp_pkg::ST_DRAIN: begin
        // The last read word is compared in this cycle.
        state_nxt = whpp_pkg::ST_RESULT;
      end
      whpp_pkg::ST_RESULT: begin
        if (!sts.pass) begin
          // First pass: keep the peak, decide on a shifted pass at the end.
          cmd.fp_store = 1'b1;
          if (sts.last_win) begin
            cmd.pass_init = 1'b1;
            cmd.pass_sel  = sts.close_any;
            state_nxt     = sts.close_any ? whpp_pkg::ST_WIN : whpp_pkg::ST_EMIT;
          end else begin
            cmd.next_win = 1'b1;
            state_nxt    = whpp_pkg::ST_WIN;
          end
        end else if (sts.out_free) begin
          // Shifted pass: each window maximum goes straight out.
          cmd.out_load = 1'b1;
          if (sts.last_win) begin
            state_nxt = whpp_pkg::ST_LOAD;
          end else begin
            cmd.next_win = 1'b1;
            state_nxt    = whpp_pkg::ST_WIN;
          end
        end
      end
      whpp_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel_fp = 1'b1;
          if (sts.last_win) begin
            state_nxt = whpp_pkg::ST_LOAD;
          end else begin
            cmd.next_win = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = whpp_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/whpp_datapath.sv
// Datapath of the windowed histogram peak picker: bin store, width divider,
// window bounds, maximum scan, first-pass peak store and output register.
// Depends on whpp_pkg and the channel interfaces.
`default_nettype none

module whpp_datapath #(
  parameter int MAX_BINS    = whpp_pkg::MAX_BINS_DEF,
  parameter int MAX_WINDOWS = whpp_pkg::MAX_WINDOWS_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  whpp_in_if.sink         in_ch,
  whpp_out_if.source      out_ch,
  whpp_cfg_if.sink        cfg_ch,
  input  whpp_pkg::cmd_t  cmd,
  output whpp_pkg::sts_t  sts
);

  localparam int NB_W = $clog2(MAX_BINS + 1);
  localparam int AW   = $clog2(MAX_BINS);
  localparam int NW_W = $clog2(MAX_WINDOWS + 1);
  localparam int IW   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int SW   = NB_W + 3;
  localparam int DC_W = $clog2(NB_W + 1);
  localparam int CW   = whpp_pkg::BIN_COUNT_W;
  localparam int PW   = whpp_pkg::PEAK_BIN_W;

  localparam logic signed [SW-1:0] S_ONE = SW'(1);
  localparam logic signed [SW-1:0] S_TWO = SW'(2);

  // Configuration and run registers.
  logic [whpp_pkg::NUM_WINDOWS_W-1:0] num_windows_r;
  logic [NB_W-1:0]                    cnt_r;
  logic [NB_W-1:0]                    nb_r;
  logic [NW_W-1:0]                    nw_r;

  // Divider registers; the quotient register ends up holding the width.
  logic [NB_W-1:0] quo_r;
  logic [NW_W-1:0] rem_r;
  logic [DC_W-1:0] div_cnt_r;

  // Window walk and scan registers.
  logic signed [SW-1:0] start_r;
  logic [NW_W-1:0]      win_r;
  logic                 pass_r;
  logic                 close_r;
  logic [NB_W-1:0]      hi_r;
  logic [NB_W-1:0]      scan_bin_r;
  logic [CW-1:0]        rd_data_r;
  logic [NB_W-1:0]      rd_bin_r;
  logic                 rd_vld_r;
  logic [NB_W-1:0]      best_bin_r;
  logic [CW-1:0]        best_cnt_r;
  logic [NB_W-1:0]      prev_bin_r;

  // First-pass peaks and the bin store.
  logic [NB_W-1:0] fp_bin_r [MAX_WINDOWS];
  logic [CW-1:0]   fp_cnt_r [MAX_WINDOWS];
  logic [CW-1:0]   bin_mem  [MAX_BINS];

  // Output register.
  logic            out_valid_r;
  logic [PW-1:0]   out_bin_r;
  logic [CW-1:0]   out_cnt_r;
  logic            out_shift_r;
  logic            out_last_r;

  // Combinational terms.
  logic                 in_acc;
  logic                 cnt_full;
  logic [NB_W-1:0]      nb_new;
  logic [NW_W-1:0]      nw_clamp;
  logic [NW_W:0]        rem_sh;
  logic                 div_ge;
  logic [NW_W:0]        rem_sub;
  logic signed [SW-1:0] range_s;
  logic signed [SW-1:0] nb_s;
  logic signed [SW-1:0] end_raw;
  logic signed [SW-1:0] end_cap;
  logic signed [SW-1:0] lo_s;
  logic signed [SW-1:0] hi_s;
  logic [NB_W-1:0]      rd_addr_full;
  logic [AW-1:0]        rd_addr;
  logic [NB_W-1:0]      diff;
  logic [NB_W+1:0]      tri_p1;
  logic                 close_hit;
  logic [NW_W-1:0]      win_inc;
  logic [IW-1:0]        win_idx;
  logic [NB_W-1:0]      sel_bin;
  logic [CW-1:0]        sel_cnt;
  logic [NB_W+PW-1:0]   sel_bin_ext;

  assign in_ch.ready  = cmd.load;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = cmd.load & in_ch.valid;

  // Bin counting; bins past the end of the store are dropped.
  assign cnt_full = (cnt_r == NB_W'(MAX_BINS));
  assign nb_new   = cnt_full ? cnt_r : cnt_r + NB_W'(1);

  // Window count as used by a run, clamped to the supported range.
  always_comb begin
    priority if (num_windows_r == '0) begin
      nw_clamp = NW_W'(1);
    end else if (32'(num_windows_r) > 32'(MAX_WINDOWS)) begin
      nw_clamp = NW_W'(MAX_WINDOWS);
    end else begin
      nw_clamp = NW_W'(num_windows_r);
    end
  end

  // Restoring divider, one quotient bit per step.
  assign rem_sh  = {rem_r, quo_r[NB_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, nw_r});
  assign rem_sub = rem_sh - {1'b0, nw_r};

  // Bounds of the current window, with the end capped near the top bins.
  assign range_s = $signed({3'b000, quo_r});
  assign nb_s    = $signed({3'b000, nb_r});
  assign end_raw = start_r + range_s;
  assign end_cap = (end_raw > nb_s - S_ONE) ? nb_s - S_TWO : end_raw;
  assign lo_s    = (start_r < S_ONE) ? S_ONE : start_r;
  assign hi_s    = (end_cap > nb_s) ? nb_s : end_cap;

  // Store address of the bin being read.
  assign rd_addr_full = scan_bin_r - NB_W'(1);
  assign rd_addr      = rd_addr_full[AW-1:0];

  // Closeness of this peak to the previous one: 3*d + 1 < width.
  assign diff      = (best_bin_r >= prev_bin_r) ? best_bin_r - prev_bin_r
                                                : prev_bin_r - best_bin_r;
  assign tri_p1    = {2'b00, diff} + {1'b0, diff, 1'b0} + (NB_W+2)'(1);
  assign close_hit = (win_r != '0) && (tri_p1 < {2'b00, quo_r});

  assign win_inc = win_r + NW_W'(1);
  assign win_idx = win_r[IW-1:0];

  // Result source: the live scan or the first-pass store.
  assign sel_bin     = cmd.out_sel_fp ? fp_bin_r[win_idx] : best_bin_r;
  assign sel_cnt     = cmd.out_sel_fp ? fp_cnt_r[win_idx] : best_cnt_r;
  assign sel_bin_ext = {{PW{1'b0}}, sel_bin};

  // Status to the controller.
  assign sts.acc_last  = in_acc & in_ch.last_bin;
  assign sts.div_done  = (div_cnt_r == DC_W'(NB_W));
  assign sts.win_empty = (hi_s < lo_s);
  assign sts.scan_last = (scan_bin_r == hi_r);
  assign sts.last_win  = (win_inc == nw_r);
  assign sts.close_any = close_r | close_hit;
  assign sts.pass      = pass_r;
  assign sts.out_free  = ~out_valid_r | out_ch.ready;

  // Window count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_windows_r <= whpp_pkg::NUM_WINDOWS_RST;
    end else if (cfg_ch.valid) begin
      num_windows_r <= cfg_ch.num_windows;
    end
  end

  // Bin counter, cleared when the histogram closes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= in_ch.last_bin ? '0 : nb_new;
    end
  end

  // Bin store write and scan read.
  always_ff @(posedge clk) begin
    if (in_acc && !cnt_full) begin
      bin_mem[cnt_r[AW-1:0]] <= in_ch.bin_count;
    end
    if (cmd.scan_step) begin
      rd_data_r <= bin_mem[rd_addr];
    end
  end

  // Run setup and width division.
  always_ff @(posedge clk) begin
    if (sts.acc_last) begin
      nb_r      <= nb_new;
      nw_r      <= nw_clamp;
      quo_r     <= nb_new;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= div_ge ? rem_sub[NW_W-1:0] : rem_sh[NW_W-1:0];
      quo_r     <= {quo_r[NB_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + DC_W'(1);
    end
  end

  // Window walk: start bin, window number and pass.
  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      start_r <= cmd.pass_sel ? $signed({4'b0000, quo_r[NB_W-1:1]}) : S_ONE;
      win_r   <= '0;
      pass_r  <= cmd.pass_sel;
    end else if (cmd.next_win) begin
      start_r <= start_r + range_s;
      win_r   <= win_inc;
    end
  end

  // Closeness flag over the first pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_r <= 1'b0;
    end else if (sts.acc_last) begin
      close_r <= 1'b0;
    end else if (cmd.fp_store) begin
      close_r <= close_r | close_hit;
    end
  end

  // Scan address and read tag pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_setup) begin
      scan_bin_r <= lo_s[NB_W-1:0];
      hi_r       <= hi_s[NB_W-1:0];
    end else if (cmd.scan_step) begin
      scan_bin_r <= scan_bin_r + NB_W'(1);
    end
    if (cmd.scan_step) begin
      rd_bin_r <= scan_bin_r;
    end
  end

  // Running maximum; a strictly larger count moves the peak, so the first
  // bin holding the maximum wins. An empty window reports bin and count 0.
  always_ff @(posedge clk) begin
    if (cmd.win_setup) begin
      best_bin_r <= sts.win_empty ? '0 : lo_s[NB_W-1:0];
      best_cnt_r <= '0;
    end else if (rd_vld_r && (rd_data_r > best_cnt_r)) begin
      best_bin_r <= rd_bin_r;
      best_cnt_r <= rd_data_r;
    end
  end

  // First-pass peak store.
  always_ff @(posedge clk) begin
    if (cmd.fp_store) begin
      fp_bin_r[win_idx] <= best_bin_r;
      fp_cnt_r[win_idx] <= best_cnt_r;
      prev_bin_r        <= best_bin_r;
    end
  end

  // Output register; a result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bin_r   <= sel_bin_ext[PW-1:0];
      out_cnt_r   <= sel_cnt;
      out_shift_r <= pass_r;
      out_last_r  <= sts.last_win;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_bin       = out_bin_r;
  assign out_ch.peak_count     = out_cnt_r;
  assign out_ch.window_shifted = out_shift_r;
  assign out_ch.last_peak      = out_last_r;

`ifndef SYNTHESIS
  // A result is never loaded over one that has not been transferred.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output register is occupied");

  // Every scanned bin lies inside the loaded histogram and at or below the window end.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (scan_bin_r != '0) && (scan_bin_r <= nb_r) && (scan_bin_r <= hi_r))
    else $error("scan address outside the loaded bins");

  // The bin counter never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NB_W'(MAX_BINS))
    else $error("bin counter beyond the store depth");

  // Peaks are stored or sent only for windows of the current run.
  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fp_store || cmd.out_load) |-> (win_r < nw_r))
    else $error("window number beyond the window count");
`endif

endmodule

`default_nettype wire

FILE: tb/whpp_checker.sv
`timescale 1ns / 1ps
// Checker for the windowed histogram peak picker: watches the bin, window count
// and peak channels, predicts the peaks of each histogram and compares them.
// Depends on whpp_pkg and the channel interfaces in whpp_channels.sv.

module whpp_checker #(
  parameter int MAX_BINS    = whpp_pkg::MAX_BINS_DEF,
  parameter int MAX_WINDOWS = whpp_pkg::MAX_WINDOWS_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  whpp_in_if   in_ch,
  whpp_out_if  out_ch,
  whpp_cfg_if  cfg_ch,
  output int   fail_count,
  output int   peaks_pending,
  output int   peaks_checked,
  output int   shifted_peaks
);
  import whpp_pkg::*;

  typedef struct packed {
    logic [PEAK_BIN_W-1:0]  bin;
    logic [BIN_COUNT_W-1:0] count;
    logic                   shifted;
    logic                   last;
  } peak_t;

  // Own copy of the histogram, the fill level and the window count register.
  logic [BIN_COUNT_W-1:0]   hist_mem [MAX_BINS];
  int                       n_loaded;
  logic [NUM_WINDOWS_W-1:0] windows_reg;
  peak_t                    expected_peaks [$];
  int                       n_fail    = 0;
  int                       n_checked = 0;
  int                       n_shifted = 0;

  // First bin holding the largest count over an inclusive range, clipped to
  // the loaded bins; an empty range gives bin 0 and count 0.
  function automatic void find_window_max(input longint lo, input longint hi,
                                          input int nb,
                                          output logic [PEAK_BIN_W-1:0] pk_bin,
                                          output logic [BIN_COUNT_W-1:0] pk_cnt);
    if (lo < 1) lo = 1;
    if (hi > nb) hi = nb;
    pk_bin = '0;
    pk_cnt = '0;
    if (hi >= lo) begin
      pk_bin = lo[PEAK_BIN_W-1:0];
      pk_cnt = hist_mem[lo-1];
      for (longint b = lo + 1; b <= hi; b++) begin
        if (hist_mem[b-1] > pk_cnt) begin
          pk_cnt = hist_mem[b-1];
          pk_bin = b[PEAK_BIN_W-1:0];
        end
      end
    end
  endfunction

  // Window end, pulled back to two below the bin count near the top.
  function automatic longint window_stop(input longint start, input longint width,
                                         input longint nb);
    longint e;
    e = start + width;
    if (e > nb - 1) e = nb - 2;
    return e;
  endfunction

  // Works out every peak of the histogram just closed and queues them.
  function automatic void predict_peaks();
    int                     nb;
    int                     nw;
    longint                 width;
    longint                 start;
    longint                 d;
    logic                   close_pair;
    logic [PEAK_BIN_W-1:0]  fp_bin [MAX_WINDOWS];
    logic [BIN_COUNT_W-1:0] fp_cnt [MAX_WINDOWS];
    logic [PEAK_BIN_W-1:0]  pb;
    logic [BIN_COUNT_W-1:0] pc;
    peak_t                  pk;
    nb = n_loaded;
    n_loaded = 0;
    nw = int'(windows_reg);
    if (nw < 1) nw = 1;
    if (nw > MAX_WINDOWS) nw = MAX_WINDOWS;
    width = nb / nw;

    // First pass over windows starting at bin one.
    start = 1;
    for (int w = 0; w < nw; w++) begin
      find_window_max(start, window_stop(start, width, nb), nb, fp_bin[w], fp_cnt[w]);
      start += width;
    end

    // Neighbouring peaks closer than two sigma force the shifted pass.
    close_pair = 1'b0;
    for (int w = 1; w < nw; w++) begin
      d = longint'(fp_bin[w]) - longint'(fp_bin[w-1]);
      if (d < 0) d = -d;
      if (3 * d < width - 1) close_pair = 1'b1;
    end

    start = width / 2;
    for (int w = 0; w < nw; w++) begin
      if (close_pair) begin
        find_window_max(start, window_stop(start, width, nb), nb, pb, pc);
        start += width;
      end else begin
        pb = fp_bin[w];
        pc = fp_cnt[w];
      end
      pk.bin     = pb;
      pk.count   = pc;
      pk.shifted = close_pair;
      pk.last    = (w == nw - 1);
      expected_peaks = {expected_peaks, pk};
    end
  endfunction

  function automatic void compare_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      n_fail++;
    end
  endfunction

  // Every transfer is taken at the clock edge; the count outputs are registered.
  always @(posedge clk) begin
    peak_t got;
    peak_t want;
    if (!rst_n) begin
      n_loaded    = 0;
      windows_reg = NUM_WINDOWS_RST;
      expected_peaks.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.bin     = out_ch.peak_bin;
        got.count   = out_ch.peak_count;
        got.shifted = out_ch.window_shifted;
        got.last    = out_ch.last_peak;
        if (expected_peaks.size() == 0) begin
          $error("peak transfer with none expected: bin %0d count %0d", got.bin, got.count);
          n_fail++;
        end else begin
          want = expected_peaks.pop_front();
          compare_field("peak_bin", want.bin, got.bin);
          compare_field("peak_count", want.count, got.count);
          compare_field("window_shifted", want.shifted, got.shifted);
          compare_field("last_peak", want.last, got.last);
          n_checked++;
          if (want.shifted) n_shifted++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) windows_reg = cfg_ch.num_windows;
      if (in_ch.valid && in_ch.ready) begin
        // Bins past the end of the store are dropped.
        if (n_loaded < MAX_BINS) begin
          hist_mem[n_loaded] = in_ch.bin_count;
          n_loaded++;
        end
        if (in_ch.last_bin) predict_peaks();
      end
    end
    fail_count    <= n_fail;
    peaks_pending <= expected_peaks.size();
    peaks_checked <= n_checked;
    shifted_peaks <= n_shifted;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the windowed histogram peak picker: clock, reset, bin and
// window count stimulus, receiver stalls and the verdict. Depends on whpp_pkg,
// the channel interfaces, the block itself and whpp_checker.

module tb;
  import whpp_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_BINS   = 350;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKY} rx_mode_t;
  typedef enum int {SHAPE_NOISE, SHAPE_LOW, SHAPE_SPIKES, SHAPE_EDGES, SHAPE_FLAT} shape_t;
  typedef logic [BIN_COUNT_W-1:0] bin_list_t [$];

  logic clk = 1'b0;
  logic rst_n;
  logic hold_kick;
  int   fail_count;
  int   peaks_pending;
  int   peaks_checked;
  int   shifted_peaks;
  int   burst_left;
  logic gaps_on;
  int   bins_sent;
  int   hists_sent;
  int   cur_windows;

  whpp_in_if  in_ch ();
  whpp_out_if out_ch ();
  whpp_cfg_if cfg_ch ();

  windowed_histogram_peak_picker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  whpp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .peaks_pending (peaks_pending),
    .peaks_checked (peaks_checked),
    .shifted_peaks (shifted_peaks)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One bin transfer, followed now and then by a gap when bursts are enabled.
  task automatic push_bin(input logic [BIN_COUNT_W-1:0] value, input logic last);
    in_ch.valid     <= 1'b1;
    in_ch.bin_count <= value;
    in_ch.last_bin  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bins_sent++;
    if (gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 16);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic send_values(input bin_list_t values);
    foreach (values[i]) push_bin(values[i], i == values.size() - 1);
    hists_sent++;
  endtask

  // Histogram contents of a given shape; edge shapes put tall bins around
  // window boundaries so that neighbouring peaks tend to fall close together.
  function automatic bin_list_t shaped_bins(input int size, input shape_t shape);
    bin_list_t              values;
    int                     width;
    logic [BIN_COUNT_W-1:0] level;
    logic [BIN_COUNT_W-1:0] entry;
    width = size / cur_windows;
    level = $urandom();
    for (int i = 1; i <= size; i++) begin
      case (shape)
        SHAPE_NOISE:  entry = $urandom();
        SHAPE_LOW:    entry = $urandom_range(0, 7);
        SHAPE_SPIKES: entry = ($urandom_range(0, 7) == 0) ? $urandom() : 0;
        SHAPE_EDGES: begin
          if (width > 0 && (i % width) <= 1) entry = $urandom_range(1000, 16777215);
          else entry = $urandom_range(0, 999);
        end
        default: entry = level;
      endcase
      values = {values, entry};
    end
    return values;
  endfunction

  // Stops offering bins until every predicted peak has been transferred.
  task automatic await_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (peaks_pending != 0) @(posedge clk);
  endtask

  // The window count is only changed with the block idle.
  task automatic write_windows(input logic [NUM_WINDOWS_W-1:0] value);
    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.num_windows <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (value == 0) cur_windows = 1;
    else if (value > MAX_WINDOWS_DEF) cur_windows = MAX_WINDOWS_DEF;
    else cur_windows = value;
  endtask

  // Receiver: stall pattern changes every so often; a kick starts a long hold.
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       hold_left;
    logic     hold_seen;
    int       tick;
    out_ch.ready <= 1'b0;
    rx_mode   = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_seen != hold_kick) begin
        hold_seen = hold_kick;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
          default:   out_ch.ready <= tick[3];
        endcase
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    bin_list_t hist;
    int        random_bins;
    int        size;
    int        hist_idx;
    int        choice;
    shape_t    shape;
    rst_n              <= 1'b0;
    hold_kick          <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.bin_count    <= '0;
    in_ch.last_bin     <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.num_windows <= '0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    bins_sent   = 0;
    hists_sent  = 0;
    cur_windows = int'(NUM_WINDOWS_RST);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset window count; the second window ends up empty.
    hist = {24'd0, 24'hFFFFFF, 24'd0, 24'd1};
    send_values(hist);
    // A histogram of one bin leaves every window empty.
    hist = {24'hABCDEF};
    send_values(hist);
    // Zero windows clamps to one; the capped window holds only the first bin.
    write_windows(5'd0);
    hist = {24'd5, 24'd5, 24'd3};
    send_values(hist);
    // Too many windows clamps to the maximum, with fewer bins than windows.
    write_windows(5'd31);
    hist = {24'd1, 24'd2, 24'd3};
    send_values(hist);
    // Two windows share their boundary bin, which forces the shifted pass.
    write_windows(5'd3);
    hist = {24'd1, 24'd2, 24'd3, 24'd4, 24'hFFFFFF, 24'd4,
            24'd3, 24'd2, 24'd1, 24'd0, 24'd9, 24'd9};
    send_values(hist);

    // Random histograms of mostly small sizes.
    random_bins = 0;
    hist_idx    = 0;
    while (random_bins < RANDOM_BINS) begin
      if ($urandom_range(0, 3) == 0) begin
        choice = $urandom_range(0, 5);
        case (choice)
          0:       write_windows(5'd1);
          1:       write_windows(5'd16);
          2:       write_windows(5'd0);
          3:       write_windows($urandom_range(17, 31));
          default: write_windows($urandom_range(1, 16));
        endcase
      end else if ($urandom_range(0, 5) == 0) begin
        await_drain();
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      shape   = shape_t'($urandom_range(0, 4));
      if (hist_idx == 6) begin
        // Long receiver hold while two histograms are pushed back to back.
        gaps_on = 1'b0;
        hold_kick <= ~hold_kick;
        send_values(shaped_bins($urandom_range(8, 24), shape));
        send_values(shaped_bins($urandom_range(8, 24), SHAPE_NOISE));
        random_bins += 32;
      end else if (hist_idx == 12) begin
        // Overfull histogram: bins beyond the store are dropped.
        send_values(shaped_bins(MAX_BINS_DEF + $urandom_range(1, 8), shape));
      end else begin
        if ($urandom_range(0, 7) == 0) size = $urandom_range(25, 120);
        else size = $urandom_range(1, 24);
        send_values(shaped_bins(size, shape));
        random_bins += size;
      end
      hist_idx++;
    end

    await_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d bins in %0d histograms, %0d peaks checked, %0d from shifted windows",
             bins_sent, hists_sent, peaks_checked, shifted_peaks);
    $display("tb: window counts from clamped low to clamped high, one %0d-cycle hold, one overfull store",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
